// ===== rtl/bdasc_pkg.sv =====
package bdasc_pkg;

  // payload widths fixed by the channel format
  localparam int unsigned VALUE_BITS = 32;
  localparam int unsigned CHAR_BITS  = 6;

  // operand width used for conversion (at most VALUE_BITS)
  localparam int unsigned INPUT_BITS = 32;

  // decimal digits needed for INPUT_BITS, floor(bits * log10(2)) + 1
  localparam int unsigned DIGITS     = (INPUT_BITS * 301) / 1000 + 1;
  localparam int unsigned BCD_BITS   = 4 * DIGITS;

  localparam int unsigned BIT_CNT_BITS   = $clog2(INPUT_BITS + 1);
  localparam int unsigned DIGIT_CNT_BITS = $clog2(DIGITS + 1);

  localparam logic [CHAR_BITS-1:0] ASCII_ZERO = CHAR_BITS'(48);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CONV = 4'b0010,
    ST_SKIP = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

endpackage

// ===== rtl/bdasc_if.sv =====
interface bdasc_in_if;
  logic                               valid;
  logic                               ready;
  logic [bdasc_pkg::VALUE_BITS-1:0]   value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface bdasc_out_if;
  logic                               valid;
  logic                               ready;
  logic [bdasc_pkg::CHAR_BITS-1:0]    digit_char;
  logic                               last_digit;

  modport source (output valid, output digit_char, output last_digit, input ready);
  modport sink   (input valid, input digit_char, input last_digit, output ready);
endinterface

// ===== rtl/binary_to_decimal_ascii.sv =====
// binary to decimal ascii: one 32-bit value in, 1 to 10 digit characters out
// flow: the input item is taken in idle, then converted by the bit-serial
//   double-dabble loop (one bit per cycle), then the one-digit-per-cycle
//   leading-zero skip and emit shifter runs; emit holds while the consumer stalls,
//   and a new input item is taken only after the last digit has been taken
// reset: synchronous, active high; returns to idle and drops output valid
module binary_to_decimal_ascii (
  input  logic          clk,
  input  logic          rst,
  bdasc_in_if.sink      num,
  bdasc_out_if.source   chr
);

  localparam int unsigned IB  = bdasc_pkg::INPUT_BITS;
  localparam int unsigned BB  = bdasc_pkg::BCD_BITS;
  localparam int unsigned ND  = bdasc_pkg::DIGITS;
  localparam int unsigned CB  = bdasc_pkg::BIT_CNT_BITS;
  localparam int unsigned DB  = bdasc_pkg::DIGIT_CNT_BITS;

  bdasc_pkg::state_t state, state_next;

  // binary operand, shifted out msb first
  logic [IB-1:0] bin;
  // bcd accumulator, most significant digit at the top
  logic [BB-1:0] bcd;
  // bcd after the add-3 correction of every digit of 5 or more
  logic [BB-1:0] bcd_adj;
  // conversion bits still to go
  logic [CB-1:0] bit_cnt;
  // digits left in the bcd word, counting the one at the top
  logic [DB-1:0] dig_left;

  logic [3:0] top_digit;
  logic       in_take;
  logic       out_take;
  logic       last_one;

  assign in_take   = num.valid && num.ready;
  assign out_take  = chr.valid && chr.ready;
  assign top_digit = bcd[BB-1 -: 4];
  assign last_one  = (dig_left == DB'(1));

  // double-dabble correction, each digit on its own
  always_comb begin
    for (int i = 0; i < ND; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4];
      end
    end
  end

  // control
  always_comb begin
    state_next = state;
    unique case (state)
      bdasc_pkg::ST_IDLE: begin
        if (in_take) state_next = bdasc_pkg::ST_CONV;
      end
      bdasc_pkg::ST_CONV: begin
        if (bit_cnt == CB'(1)) state_next = bdasc_pkg::ST_SKIP;
      end
      bdasc_pkg::ST_SKIP: begin
        // stop on the first nonzero digit, or keep the units digit
        if (top_digit != 4'd0 || last_one) state_next = bdasc_pkg::ST_EMIT;
      end
      bdasc_pkg::ST_EMIT: begin
        if (out_take && last_one) state_next = bdasc_pkg::ST_IDLE;
      end
      default: state_next = bdasc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bdasc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      bdasc_pkg::ST_IDLE: begin
        if (in_take) begin
          bin     <= num.value[IB-1:0];
          bcd     <= '0;
          bit_cnt <= CB'(IB);
        end
      end
      bdasc_pkg::ST_CONV: begin
        // shift one binary bit into the corrected bcd word
        bcd      <= {bcd_adj[BB-2:0], bin[IB-1]};
        bin      <= {bin[IB-2:0], 1'b0};
        bit_cnt  <= bit_cnt - CB'(1);
        dig_left <= DB'(ND);
      end
      bdasc_pkg::ST_SKIP: begin
        // drop one leading zero per cycle
        if (top_digit == 4'd0 && !last_one) begin
          bcd      <= {bcd[BB-5:0], 4'd0};
          dig_left <= dig_left - DB'(1);
        end
      end
      bdasc_pkg::ST_EMIT: begin
        if (out_take) begin
          bcd      <= {bcd[BB-5:0], 4'd0};
          dig_left <= dig_left - DB'(1);
        end
      end
      default: begin
      end
    endcase
  end

  assign num.ready      = (state == bdasc_pkg::ST_IDLE);
  assign chr.valid      = (state == bdasc_pkg::ST_EMIT);
  assign chr.digit_char = {{(bdasc_pkg::CHAR_BITS-4){1'b0}}, top_digit} + bdasc_pkg::ASCII_ZERO;
  assign chr.last_digit = last_one;

endmodule

// ===== rtl/bdasc_checker.sv =====
module bdasc_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [bdasc_pkg::CHAR_BITS-1:0]    out_char,
  input logic                               out_last
);

  // a stalled character holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(out_last))
    else $error("output item changed while stalled");

  // only decimal digit characters appear
  a_char_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_char >= bdasc_pkg::CHAR_BITS'(48)) &&
                  (out_char <= bdasc_pkg::CHAR_BITS'(57)))
    else $error("output character is not a decimal digit");

  // no new item is taken while a run is being emitted
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input ready while digits are pending");

  // conversion takes time: no character right after an item is taken
  a_conv_gap: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !out_valid)
    else $error("character emitted right after input item");

  // the run ends with the last digit
  a_run_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_last |=> !out_valid)
    else $error("output continues after last digit");

endmodule

bind binary_to_decimal_ascii bdasc_checker u_bdasc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (num.valid),
  .in_ready  (num.ready),
  .out_valid (chr.valid),
  .out_ready (chr.ready),
  .out_char  (chr.digit_char),
  .out_last  (chr.last_digit)
);

// ===== tb/sv/binary_to_decimal_ascii_tb.sv =====
`timescale 1ns / 100ps

module binary_to_decimal_ascii_tb;

  // run limits
  localparam int CYCLE_LIMIT  = 400000;  // well above the slowest legal run
  localparam int HOLD_CYCLES  = 600;     // long consumer hold-off
  localparam int DRAIN_CYCLES = 64;      // more than one conversion after the last digit

  // one expected output item: a character and its end-of-number flag
  typedef struct packed {
    logic [bdasc_pkg::CHAR_BITS-1:0] digit_char;
    logic                            last_digit;
  } digit_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bdasc_in_if  num_if ();
  bdasc_out_if chr_if ();

  binary_to_decimal_ascii dut (
    .clk (clk),
    .rst (rst),
    .num (num_if.sink),
    .chr (chr_if.source)
  );

  // digits still owed by the block, oldest first
  digit_item_t pending_digits[$];

  int  mismatches  = 0;
  int  cycle_count = 0;
  bit  idle_en     = 1'b1;  // random gaps on both sides
  bit  hold_req    = 1'b0;  // asks the consumer for a long hold-off

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // decimal rendering of one operand: most significant digit first, leading
  // zeros dropped, zero gives a lone '0', last digit flagged
  function automatic void predict_decimal(input logic [bdasc_pkg::VALUE_BITS-1:0] v);
    logic [63:0]  rest;
    logic [3:0]   digs[20];
    int           n;
    digit_item_t  item;
    rest = 64'(v);
    if (bdasc_pkg::INPUT_BITS < 64)
      rest = rest & ((64'd1 << bdasc_pkg::INPUT_BITS) - 64'd1);
    n = 0;
    do begin
      digs[n] = 4'(rest % 64'd10);
      rest    = rest / 64'd10;
      n++;
    end while (rest != 0 && n < 20);
    for (int k = n - 1; k >= 0; k--) begin
      item.digit_char = bdasc_pkg::CHAR_BITS'(bdasc_pkg::ASCII_ZERO +
                                              bdasc_pkg::CHAR_BITS'(digs[k]));
      item.last_digit = (k == 0);
      pending_digits.push_back(item);
    end
  endfunction

  // consumer: random stall bursts, or one long counted hold-off on request;
  // at most one assignment to ready per falling edge
  initial begin
    chr_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        chr_if.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        chr_if.ready <= 1'b0;
        repeat ($urandom_range(1, 16) - 1) @(negedge clk);
      end else begin
        chr_if.ready <= 1'b1;
      end
    end
  end

  // checker: each digit taken at a rising edge against the oldest expectation
  always @(posedge clk) begin
    digit_item_t want;
    if (!rst && chr_if.valid && chr_if.ready) begin
      if (pending_digits.size() == 0) begin
        $error("unexpected digit item: digit_char %0d last_digit %0b",
               chr_if.digit_char, chr_if.last_digit);
        mismatches++;
      end else begin
        want = pending_digits.pop_front();
        if (chr_if.digit_char !== want.digit_char) begin
          $error("digit_char: expected %0d, got %0d", want.digit_char, chr_if.digit_char);
          mismatches++;
        end
        if (chr_if.last_digit !== want.last_digit) begin
          $error("last_digit: expected %0b, got %0b", want.last_digit, chr_if.last_digit);
          mismatches++;
        end
      end
    end
  end

  // offer one value, with an optional gap first; valid stays high into the
  // next call so back-to-back items need no extra edge
  task automatic send_value(input logic [bdasc_pkg::VALUE_BITS-1:0] v);
    @(negedge clk);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      num_if.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    num_if.valid <= 1'b1;
    num_if.value <= v;
    do @(posedge clk); while (!num_if.ready);
    predict_decimal(v);
  endtask

  // random value with exactly n decimal digits (n = 1 includes zero)
  function automatic logic [bdasc_pkg::VALUE_BITS-1:0] value_with_digits(input int n);
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] span;
    lo = 64'd1;
    for (int k = 1; k < n; k++) lo = lo * 64'd10;
    hi = lo * 64'd10 - 64'd1;
    if (n == 1) lo = 64'd0;
    if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
    span = hi - lo + 64'd1;
    return bdasc_pkg::VALUE_BITS'(lo + ({$urandom, $urandom} % span));
  endfunction

  // directed: zero, digit-count boundaries, the full range and bit patterns
  task automatic test_boundaries();
    logic [bdasc_pkg::VALUE_BITS-1:0] picks[$];
    picks = '{32'd0, 32'd1, 32'd9, 32'd10, 32'd11, 32'd99, 32'd100, 32'd101,
              32'd999, 32'd1000, 32'd65535, 32'd65536, 32'd999999999,
              32'd1000000000, 32'd1000000001, 32'd1234567890, 32'd2147483647,
              32'd2147483648, 32'd4000000000, 32'd4294967294, 32'd4294967295,
              32'h5555_5555, 32'hAAAA_AAAA};
    foreach (picks[i]) send_value(picks[i]);
  endtask

  // random mix: full-range values, every digit count, and small numbers
  task automatic test_random_values(input int count);
    int mode;
    for (int i = 0; i < count; i++) begin
      mode = $urandom_range(0, 9);
      if (mode < 4)
        send_value($urandom);
      else if (mode < 8)
        send_value(value_with_digits($urandom_range(1, 10)));
      else
        send_value(bdasc_pkg::VALUE_BITS'($urandom_range(0, 255)));
    end
  endtask

  // consumer stalls for a long stretch while items keep coming, so the block
  // fills its output and then holds off its input
  task automatic test_output_backpressure();
    hold_req = 1'b1;
    for (int i = 0; i < 8; i++) send_value(value_with_digits(10));
    while (hold_req) @(posedge clk);
  endtask

  // closing stretch at full rate on both sides
  task automatic test_full_rate();
    idle_en = 1'b0;
    test_random_values(30);
  endtask

  initial begin
    // every input known from time zero
    num_if.valid = 1'b0;
    num_if.value = '0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_boundaries();
    test_random_values(140);
    test_output_backpressure();
    test_random_values(130);
    test_full_rate();

    @(negedge clk);
    num_if.valid <= 1'b0;

    // let every owed digit arrive, then watch for strays
    while (pending_digits.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/bdasc_pkg.sv
rtl/bdasc_if.sv
rtl/binary_to_decimal_ascii.sv
rtl/bdasc_checker.sv
tb/sv/binary_to_decimal_ascii_tb.sv
